// ----- rtl/idll_pkg.sv -----
`default_nettype none
package idll_pkg;

	// Request codes carried in s_tuser
	typedef enum logic [2:0] {
		OP_APPEND    = 3'd0,
		OP_INS_START = 3'd1,
		OP_INS_INDEX = 3'd2,
		OP_RM_START  = 3'd3,
		OP_RM_INDEX  = 3'd4,
		OP_RM_END    = 3'd5,
		OP_REVERSE   = 3'd6,
		OP_CLEAR     = 3'd7
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_ALLOC_W,
		ST_PLACE,
		ST_WALK,
		ST_WALK_W,
		ST_LFRONT,
		ST_LFRONT2,
		ST_LRD,
		ST_LW1,
		ST_LW2,
		ST_RMRD,
		ST_RMW1,
		ST_RMW2,
		ST_REVRD,
		ST_REVW,
		ST_FIN
	} state_t;

	localparam int VALUE_W  = 32;
	localparam int POS_W    = 7;
	localparam int LEN_W    = 7;
	localparam int STAT_W   = 2;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 48;
	localparam logic [VALUE_W-1:0] FAIL_VALUE = 32'h8000_0000;

endpackage
`default_nettype wire

// ----- rtl/idll_ram.sv -----
`default_nettype none
module idll_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, register one read (old data on a clash)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/indexed_doubly_linked_list_unit.sv -----
`default_nettype none
// Channel  Dir  tdata (low bit first)                         tuser
// s        in   value[31:0], position[38:32], zero pad       operation[2:0]
// m        out  removed_value[31:0], status[33:32],          -
//               list_length[40:34], list_empty[41], pad
//
// One item at a time. Append, insert at start and removals at the ends need no
// walk. Indexed insert or remove also walks the list from the head, with one
// read of the next-link memory per hop; reverse reads and rewrites the links
// of each node in turn. Clear and rejected requests go straight to the finish
// state. Reset is immediate: a fill mark stands in for the initial free list.
// A stalled result waits in the output register.
module indexed_doubly_linked_list_unit #(
	parameter int CAPACITY = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [idll_pkg::S_DATA_W-1:0] s_tdata,  // value, position
	input  wire logic [2:0]                    s_tuser,  // operation
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [idll_pkg::M_DATA_W-1:0] m_tdata   // removed, status, length, empty
);
	import idll_pkg::*;

	localparam int PW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int EW = (PW > POS_W) ? PW : POS_W;
	localparam logic [PW-1:0] NIL = PW'(CAPACITY);

	state_t state_q, state_d;

	logic [PW-1:0]      head_q, tail_q, free_q, fill_q, count_q;
	logic [PW-1:0]      node_q, cur_q, at_q, nx_q;
	logic [EW-1:0]      steps_q;
	op_t                op_q;
	logic [VALUE_W-1:0] val_q, rv_q;
	status_t            st_q;

	logic m_valid_q;
	logic [M_DATA_W-1:0] m_data_q;

	// Memory ports
	logic               nx_we, pv_we, v_we;
	logic [AW-1:0]      nx_wa, pv_wa, v_wa, nx_ra, pv_ra, v_ra;
	logic [PW-1:0]      nx_wd, pv_wd, n_rd, p_rd;
	logic [VALUE_W-1:0] v_rd;

	idll_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(n_rd)
	);
	idll_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(p_rd)
	);
	idll_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_value (
		.clk(clk), .we(v_we), .waddr(v_wa), .wdata(val_q), .raddr(v_ra), .rdata(v_rd)
	);

	// Decode the incoming request
	logic               acc;
	op_t                in_op;
	logic [EW-1:0]      in_pos, cnt_e;
	logic               full, empty;
	logic               out_free;
	status_t            in_st;
	logic [VALUE_W-1:0] in_rv;

	assign acc      = s_tvalid && s_tready;
	assign in_op    = op_t'(s_tuser);
	assign in_pos   = EW'(s_tdata[VALUE_W +: POS_W]);
	assign cnt_e    = EW'(count_q);
	assign full     = (count_q == NIL);
	assign empty    = (count_q == '0);
	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	// Classify rejected requests at accept time
	always_comb begin
		in_st = STAT_OK;
		in_rv = '0;
		case (in_op)
			OP_APPEND, OP_INS_START: begin
				if (full) in_st = STAT_FULL;
			end
			OP_INS_INDEX: begin
				if (in_pos > cnt_e) in_st = STAT_RANGE;
				else if (full) in_st = STAT_FULL;
			end
			OP_RM_START, OP_RM_END, OP_RM_INDEX: begin
				if (empty) begin
					in_st = STAT_EMPTY;
					in_rv = FAIL_VALUE;
				end else if (in_op == OP_RM_INDEX && in_pos >= cnt_e) begin
					in_st = STAT_RANGE;
					in_rv = FAIL_VALUE;
				end
			end
			default: ;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (in_op)
						OP_APPEND, OP_INS_START:
							state_d = full ? ST_FIN : ST_ALLOC;
						OP_INS_INDEX:
							state_d = (in_pos > cnt_e || full) ? ST_FIN : ST_ALLOC;
						OP_RM_START, OP_RM_END:
							state_d = empty ? ST_FIN : ST_RMRD;
						OP_RM_INDEX:
							state_d = (empty || in_pos >= cnt_e) ? ST_FIN : ST_WALK;
						OP_REVERSE:
							state_d = (head_q == NIL) ? ST_FIN : ST_REVRD;
						default:
							state_d = ST_FIN;
					endcase
				end
			end
			ST_ALLOC:   state_d = (free_q != NIL) ? ST_ALLOC_W : ST_PLACE;
			ST_ALLOC_W: state_d = ST_PLACE;
			ST_PLACE: begin
				case (op_q)
					OP_APPEND:    state_d = (tail_q == NIL) ? ST_LFRONT : ST_LRD;
					OP_INS_INDEX: state_d = (steps_q == '0) ? ST_LFRONT : ST_WALK;
					default:      state_d = ST_LFRONT;
				endcase
			end
			ST_WALK: begin
				if (steps_q != '0) begin
					state_d = ST_WALK_W;
				end else if (op_q == OP_INS_INDEX) begin
					state_d = ST_LRD;
				end else begin
					state_d = ST_RMRD;
				end
			end
			ST_WALK_W:  state_d = ST_WALK;
			ST_LFRONT:  state_d = ST_LFRONT2;
			ST_LFRONT2: state_d = ST_FIN;
			ST_LRD:     state_d = ST_LW1;
			ST_LW1:     state_d = ST_LW2;
			ST_LW2:     state_d = ST_FIN;
			ST_RMRD:    state_d = ST_RMW1;
			ST_RMW1:    state_d = ST_RMW2;
			ST_RMW2:    state_d = ST_FIN;
			ST_REVRD:   state_d = ST_REVW;
			ST_REVW:    state_d = (n_rd == NIL) ? ST_FIN : ST_REVRD;
			ST_FIN:     state_d = out_free ? ST_IDLE : ST_FIN;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Memory control per state
	always_comb begin
		nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_ra = '0;
		pv_we = 1'b0; pv_wa = '0; pv_wd = '0; pv_ra = '0;
		v_we  = 1'b0; v_wa  = '0; v_ra  = '0;
		case (state_q)
			ST_ALLOC: nx_ra = free_q[AW-1:0];
			ST_PLACE: begin
				v_we = 1'b1; v_wa = node_q[AW-1:0];
			end
			ST_WALK: nx_ra = cur_q[AW-1:0];
			ST_LFRONT: begin
				nx_we = 1'b1; nx_wa = node_q[AW-1:0]; nx_wd = head_q;
				pv_we = 1'b1; pv_wa = node_q[AW-1:0]; pv_wd = NIL;
			end
			ST_LFRONT2: begin
				pv_we = (head_q != NIL); pv_wa = head_q[AW-1:0]; pv_wd = node_q;
			end
			ST_LRD: nx_ra = at_q[AW-1:0];
			ST_LW1: begin
				nx_we = 1'b1; nx_wa = node_q[AW-1:0]; nx_wd = n_rd;
				pv_we = 1'b1; pv_wa = node_q[AW-1:0]; pv_wd = at_q;
			end
			ST_LW2: begin
				nx_we = 1'b1; nx_wa = at_q[AW-1:0]; nx_wd = node_q;
				pv_we = (nx_q != NIL); pv_wa = nx_q[AW-1:0]; pv_wd = node_q;
			end
			ST_RMRD: begin
				nx_ra = node_q[AW-1:0]; pv_ra = node_q[AW-1:0]; v_ra = node_q[AW-1:0];
			end
			ST_RMW1: begin
				nx_we = (p_rd != NIL); nx_wa = p_rd[AW-1:0]; nx_wd = n_rd;
				pv_we = (n_rd != NIL); pv_wa = n_rd[AW-1:0]; pv_wd = p_rd;
			end
			ST_RMW2: begin
				nx_we = 1'b1; nx_wa = node_q[AW-1:0]; nx_wd = free_q;
			end
			ST_REVRD: begin
				nx_ra = cur_q[AW-1:0]; pv_ra = cur_q[AW-1:0];
			end
			ST_REVW: begin
				nx_we = 1'b1; nx_wa = cur_q[AW-1:0]; nx_wd = p_rd;
				pv_we = 1'b1; pv_wa = cur_q[AW-1:0]; pv_wd = n_rd;
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= NIL;
			tail_q    <= NIL;
			free_q    <= NIL;
			fill_q    <= '0;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Load a finished result, or drop the one taken by the receiver
			if (state_q == ST_FIN && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc && in_op == OP_CLEAR) begin
						head_q  <= NIL;
						tail_q  <= NIL;
						free_q  <= NIL;
						fill_q  <= '0;
						count_q <= '0;
					end
				end
				ST_ALLOC: begin
					count_q <= count_q + 1'b1;
					if (free_q == NIL) begin
						fill_q <= fill_q + 1'b1;
					end
				end
				ST_ALLOC_W: free_q <= n_rd;
				ST_LFRONT2: begin
					if (head_q == NIL) begin
						tail_q <= node_q;
					end
					head_q <= node_q;
				end
				ST_LW2: begin
					if (nx_q == NIL) begin
						tail_q <= node_q;
					end
				end
				ST_RMW1: begin
					if (p_rd == NIL) begin
						head_q <= n_rd;
					end
					if (n_rd == NIL) begin
						tail_q <= p_rd;
					end
				end
				ST_RMW2: begin
					free_q  <= node_q;
					count_q <= count_q - 1'b1;
				end
				ST_REVW: begin
					if (n_rd == NIL) begin
						head_q <= tail_q;
						tail_q <= head_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers of the current item
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q  <= in_op;
				val_q <= s_tdata[VALUE_W-1:0];
				rv_q  <= in_rv;
				st_q  <= in_st;
				cur_q <= head_q;
				steps_q <= in_pos;
				node_q <= (in_op == OP_RM_END) ? tail_q : head_q;
			end
			ST_ALLOC:   node_q <= (free_q != NIL) ? free_q : fill_q;
			ST_PLACE: begin
				at_q    <= tail_q;
				cur_q   <= head_q;
				steps_q <= steps_q - 1'b1;
			end
			ST_WALK: begin
				at_q <= cur_q;
				if (op_q != OP_INS_INDEX) node_q <= cur_q;
			end
			ST_WALK_W: begin
				cur_q   <= n_rd;
				steps_q <= steps_q - 1'b1;
			end
			ST_LW1:  nx_q <= n_rd;
			ST_RMW1: rv_q <= v_rd;
			ST_REVW: cur_q <= n_rd;
			default: ;
		endcase
		if (state_q == ST_FIN && out_free) begin
			m_data_q <= {
				{(M_DATA_W - VALUE_W - STAT_W - LEN_W - 1){1'b0}},
				empty,
				cnt_e[LEN_W-1:0],
				st_q,
				rv_q
			};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NIL)
		else $error("element count above capacity");
	a_head_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ((head_q == NIL) == (count_q == '0)))
		else $error("head pointer disagrees with element count");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !s_tready)
		else $error("second item taken while one is in work");
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[VALUE_W+STAT_W+LEN_W] ==
			(m_tdata[VALUE_W+STAT_W +: LEN_W] == '0)))
		else $error("empty flag disagrees with length");

endmodule
`default_nettype wire

// ----- tb/sv/tb_indexed_doubly_linked_list_unit.sv -----
`timescale 1ns / 1ps
module tb_indexed_doubly_linked_list_unit;
	import idll_pkg::*;

	localparam int CAP = 64;
	localparam int NUM_RANDOM = 1030;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic [31:0] NO_CHECK = 32'h1234_5678;

	typedef struct packed {
		logic [31:0] removed;
		status_t     stat;
		logic [6:0]  len;
		logic        empty;
	} list_result_t;

	typedef struct {
		op_t         op;
		logic [31:0] value;
		logic [6:0]  pos;
		logic        typed;
		list_result_t res;
	} request_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	// Shadow of the list contents, head first
	logic [31:0] list_shadow[$];
	list_result_t expected_results[$];
	int mismatches = 0;
	int cycles = 0;
	bit hold_off = 1'b0;
	bit idle_on = 1'b1;
	bit stim_done = 1'b0;

	indexed_doubly_linked_list_unit #(.CAPACITY(CAP)) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Compute the result of one request and update the shadow list
	function automatic list_result_t apply_request(op_t op, logic [31:0] v, logic [6:0] pos);
		list_result_t r;
		int n;
		logic [31:0] tmp[$];
		r.removed = '0;
		r.stat = STAT_OK;
		n = list_shadow.size();
		case (op)
			OP_APPEND: begin
				if (n >= CAP) r.stat = STAT_FULL;
				else list_shadow.push_back(v);
			end
			OP_INS_START: begin
				if (n >= CAP) r.stat = STAT_FULL;
				else list_shadow.push_front(v);
			end
			OP_INS_INDEX: begin
				if (pos > n) r.stat = STAT_RANGE;
				else if (n >= CAP) r.stat = STAT_FULL;
				else list_shadow.insert(pos, v);
			end
			OP_RM_START, OP_RM_INDEX, OP_RM_END: begin
				if (n == 0) begin
					r.stat = STAT_EMPTY;
					r.removed = FAIL_VALUE;
				end else if (op == OP_RM_INDEX && pos >= n) begin
					r.stat = STAT_RANGE;
					r.removed = FAIL_VALUE;
				end else if (op == OP_RM_START) begin
					r.removed = list_shadow.pop_front();
				end else if (op == OP_RM_END) begin
					r.removed = list_shadow.pop_back();
				end else begin
					r.removed = list_shadow[pos];
					list_shadow.delete(pos);
				end
			end
			OP_REVERSE: begin
				tmp = {};
				foreach (list_shadow[i]) tmp.push_front(list_shadow[i]);
				list_shadow = tmp;
			end
			default: list_shadow = {};
		endcase
		r.len = 7'(list_shadow.size());
		r.empty = (list_shadow.size() == 0);
		return r;
	endfunction

	// Offer one request and hold it until accepted
	task automatic send_request(op_t op, logic [31:0] v, logic [6:0] pos, bit typed,
			list_result_t want);
		list_result_t got;
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 11);
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, pos, v};
		s_tuser <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		got = apply_request(op, v, pos);
		if (typed && got !== want && mismatches < 10)
			$display("table row mismatch: op %s removed %h/%h status %0d/%0d len %0d/%0d",
				op.name(), want.removed, got.removed, want.stat, got.stat,
				want.len, got.len);
		if (typed && got !== want) mismatches++;
		expected_results.push_back(typed ? want : got);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic list_result_t res(logic [31:0] rv, status_t st, int len);
		list_result_t r;
		r.removed = rv;
		r.stat = st;
		r.len = 7'(len);
		r.empty = (len == 0);
		return r;
	endfunction

	// Stimulus: directed table, then random requests
	initial begin
		request_row_t rows[$];
		request_row_t row;
		op_t op;
		logic [31:0] v;
		logic [6:0] pos;
		int n;
		int pick;
		rows = '{
			'{OP_RM_START, 32'd5, 7'd0, 1'b1, res(FAIL_VALUE, STAT_EMPTY, 0)},
			'{OP_RM_INDEX, 32'd0, 7'd0, 1'b1, res(FAIL_VALUE, STAT_EMPTY, 0)},
			'{OP_RM_END, 32'd0, 7'd127, 1'b1, res(FAIL_VALUE, STAT_EMPTY, 0)},
			'{OP_REVERSE, 32'd0, 7'd0, 1'b1, res(0, STAT_OK, 0)},
			'{OP_INS_INDEX, 32'd9, 7'd1, 1'b1, res(0, STAT_RANGE, 0)},
			'{OP_INS_INDEX, 32'h8000_0000, 7'd0, 1'b1, res(0, STAT_OK, 1)},
			'{OP_APPEND, 32'h7fff_ffff, 7'd0, 1'b1, res(0, STAT_OK, 2)},
			'{OP_INS_START, 32'hffff_ffff, 7'd127, 1'b1, res(0, STAT_OK, 3)},
			'{OP_INS_INDEX, 32'h0000_0001, 7'd3, 1'b0, res(0, STAT_OK, 0)},
			'{OP_INS_INDEX, 32'h5555_aaaa, 7'd2, 1'b0, res(0, STAT_OK, 0)},
			'{OP_INS_INDEX, 32'h1, 7'd127, 1'b1, res(0, STAT_RANGE, 5)},
			'{OP_REVERSE, 32'd0, 7'd0, 1'b0, res(0, STAT_OK, 0)},
			'{OP_RM_INDEX, 32'd0, 7'd5, 1'b1, res(FAIL_VALUE, STAT_RANGE, 5)},
			'{OP_RM_INDEX, 32'd0, 7'd127, 1'b1, res(FAIL_VALUE, STAT_RANGE, 5)},
			'{OP_RM_INDEX, 32'd0, 7'd2, 1'b0, res(0, STAT_OK, 0)},
			'{OP_RM_START, 32'd0, 7'd0, 1'b0, res(0, STAT_OK, 0)},
			'{OP_RM_END, 32'd0, 7'd0, 1'b0, res(0, STAT_OK, 0)},
			'{OP_CLEAR, 32'd0, 7'd0, 1'b1, res(0, STAT_OK, 0)},
			'{OP_APPEND, 32'd3, 7'd0, 1'b1, res(0, STAT_OK, 1)},
			'{OP_RM_INDEX, 32'd0, 7'd0, 1'b1, res(32'd3, STAT_OK, 0)}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			row = rows[i];
			send_request(row.op, row.value, row.pos, row.typed, row.res);
		end
		// Fill the pool to capacity, hit full on every insert kind, then check range, reverse and remove on the full list
		while (list_shadow.size() < CAP)
			send_request(OP_APPEND, $urandom(), 7'd0, 1'b0, res(0, STAT_OK, 0));
		send_request(OP_APPEND, 32'd1, 7'd0, 1'b1, res(0, STAT_FULL, CAP));
		send_request(OP_INS_START, 32'd1, 7'd0, 1'b1, res(0, STAT_FULL, CAP));
		send_request(OP_INS_INDEX, 32'd1, 7'd64, 1'b1, res(0, STAT_FULL, CAP));
		send_request(OP_INS_INDEX, 32'd1, 7'd65, 1'b1, res(0, STAT_RANGE, CAP));
		send_request(OP_REVERSE, 32'd0, 7'd0, 1'b0, res(0, STAT_OK, 0));
		send_request(OP_RM_INDEX, 32'd0, 7'd63, 1'b0, res(0, STAT_OK, 0));
		// Pause until every result has come back
		wait_drained();
		for (int k = 0; k < NUM_RANDOM; k++) begin
			if (k == 300) hold_off = 1'b1;
			if (k == NUM_RANDOM - 120) idle_on = 1'b0;
			n = list_shadow.size();
			pick = $urandom_range(0, 99);
			// Favor inserts on short lists, removals on long ones
			if (pick < 2) op = OP_CLEAR;
			else if (pick < 6) op = OP_REVERSE;
			else if ($urandom_range(0, CAP) >= n) op = op_t'($urandom_range(0, 2));
			else op = op_t'($urandom_range(3, 5));
			v = $urandom();
			if ($urandom_range(0, 9) == 0) pos = 7'($urandom_range(0, 127));
			else pos = 7'($urandom_range(0, n));
			send_request(op, v, pos, 1'b0, res(0, STAT_OK, 0));
		end
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	// Long receiver stall so the block backs up its input
	initial begin
		wait (hold_off);
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
	end

	// Drive tready with random stall bursts
	initial begin
		int gap;
		m_tready <= 1'b0;
		wait (arst_n);
		forever begin
			if (hold_off || (idle_on && $urandom_range(0, 3) == 0)) begin
				m_tready <= 1'b0;
				gap = hold_off ? 1 : $urandom_range(1, 11);
				repeat (gap) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		list_result_t want;
		list_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.removed = m_tdata[31:0];
			got.stat = status_t'(m_tdata[33:32]);
			got.len = m_tdata[40:34];
			got.empty = m_tdata[41];
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", m_tdata);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: removed %h/%h status %0d/%0d len %0d/%0d empty %0b/%0b",
							want.removed, got.removed, want.stat, got.stat,
							want.len, got.len, want.empty, got.empty);
				end
			end
		end
	end

	// End of run and timeout
	initial begin
		wait (stim_done);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

endmodule
